@@ rtl/hsv2rgb_pkg.sv @@
// ---------------------------------------------------------------------------
// HSV to RGB converter package
// Fixed-point constants and sector codes shared by the converter.
// ---------------------------------------------------------------------------
package hsv2rgb_pkg;

   localparam int HUE_W  = 15;
   localparam int CH_W   = 8;
   localparam int FRAC_W = 12;
   localparam int SEC_W  = 3;
   localparam int RAMP_W = 20;

   // One sixty-degree sector and one full turn, in 1/64 degree.
   localparam logic [HUE_W-1:0]  SECTOR_SPAN = 15'd3840;
   localparam logic [HUE_W-1:0]  FULL_TURN   = 15'd23040;
   localparam logic [CH_W-1:0]   UNIT        = 8'd255;
   // 255 * 3840
   localparam logic [RAMP_W-1:0] RAMP_DEN    = 20'd979200;

   // ceil(2^23 / 255): exact floor division by 255 for products below 2^16.
   localparam logic [15:0] P_RECIP  = 16'd32897;
   localparam int          P_SHIFT  = 23;
   // ceil(2^32 / 3825): exact floor division by 3825 for values below 2^20.
   localparam logic [20:0] Q_RECIP  = 21'd1122868;
   localparam int          Q_SHIFT  = 32;

   localparam logic [SEC_W-1:0] SEC_RED_UP      = 3'd0;
   localparam logic [SEC_W-1:0] SEC_GREEN_RISE  = 3'd1;
   localparam logic [SEC_W-1:0] SEC_GREEN_UP    = 3'd2;
   localparam logic [SEC_W-1:0] SEC_BLUE_RISE   = 3'd3;
   localparam logic [SEC_W-1:0] SEC_BLUE_UP     = 3'd4;

endpackage

@@ rtl/hsv_to_rgb_converter_top.sv @@
// A transaction accepted at one clock edge passes the five register stages below and
// shows its result on the rsp_ ports, strobed by rsp_valid for one cycle.
// Throughput: one transaction per clock; busy is never asserted, the five register
// stages (sector split, ramp products, scaling products, reciprocal quotients, routing)
// all advance every cycle.
// Reset: synchronous, clears the stage valid bits only; transactions in flight are dropped.
// ---------------------------------------------------------------------------
// HSV to RGB converter
// Pipelined fixed-point HSV to RGB conversion, one color per clock.
// ---------------------------------------------------------------------------
module hsv_to_rgb_converter_top
   import hsv2rgb_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [HUE_W-1:0]     req_hue,
   input  logic [CH_W-1:0]      req_saturation,
   input  logic [CH_W-1:0]      req_brightness,
   output logic                 rsp_valid,
   output logic [CH_W-1:0]      rsp_red,
   output logic [CH_W-1:0]      rsp_green,
   output logic [CH_W-1:0]      rsp_blue
);

   localparam int PP_W  = 2 * CH_W;
   localparam int YQ_W  = CH_W + RAMP_W;
   localparam int PD_W  = PP_W + 15;
   localparam int QP_W  = RAMP_W + 21;

   logic accept;

   // Stage 1: hue wrap, sector and position within sector.
   logic                v1_ff, v1_in;
   logic [SEC_W-1:0]    sec1_ff, sec1_in;
   logic [FRAC_W-1:0]   f1_ff, f1_in;
   logic [CH_W-1:0]     s1_ff, v_1_ff;
   logic [HUE_W-1:0]    hw;
   logic [HUE_W-1:0]    base;

   // Stage 2: ramp products.
   logic                v2_ff;
   logic [SEC_W-1:0]    sec2_ff;
   logic [CH_W-1:0]     v_2_ff;
   logic [RAMP_W-1:0]   sf2_ff, sf2_in;
   logic [RAMP_W-1:0]   sg2_ff, sg2_in;
   logic [PP_W-1:0]     pp2_ff, pp2_in;
   logic [FRAC_W-1:0]   g1;

   // Stage 3: value scaling products.
   logic                v3_ff;
   logic [SEC_W-1:0]    sec3_ff;
   logic [CH_W-1:0]     v_3_ff;
   logic [YQ_W-1:0]     yq3_ff, yq3_in;
   logic [YQ_W-1:0]     yt3_ff, yt3_in;
   logic [PD_W-1:0]     pd3_ff, pd3_in;

   // Stage 4: quotients.
   logic                v4_ff;
   logic [SEC_W-1:0]    sec4_ff;
   logic [CH_W-1:0]     v_4_ff;
   logic [CH_W-1:0]     q4_ff, q4_in;
   logic [CH_W-1:0]     t4_ff, t4_in;
   logic [CH_W-1:0]     p4_ff, p4_in;
   logic [QP_W-1:0]     qprod, tprod;

   // Stage 5: output registers.
   logic                rsp_valid_ff;
   logic [CH_W-1:0]     red_ff, red_in;
   logic [CH_W-1:0]     green_ff, green_in;
   logic [CH_W-1:0]     blue_ff, blue_in;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_comb begin
      hw = (req_hue >= FULL_TURN) ? '0 : req_hue;
      sec1_in = SEC_RED_UP;
      base    = '0;
      for (int k = 1; k < 6; k++) begin
         if (hw >= HUE_W'(k * 3840)) begin
            sec1_in = SEC_W'(k);
            base    = HUE_W'(k * 3840);
         end
      end
      f1_in = FRAC_W'(hw - base);
      v1_in = accept;
   end

   always_comb begin
      g1     = FRAC_W'(SECTOR_SPAN) - f1_ff;
      sf2_in = {{(RAMP_W-CH_W){1'b0}}, s1_ff} * {{(RAMP_W-FRAC_W){1'b0}}, f1_ff};
      sg2_in = {{(RAMP_W-CH_W){1'b0}}, s1_ff} * {{(RAMP_W-FRAC_W){1'b0}}, g1};
      pp2_in = {{CH_W{1'b0}}, v_1_ff} * {{CH_W{1'b0}}, UNIT - s1_ff};
   end

   // Zero saturation needs no special path: p, q and t all reduce to the value.
   always_comb begin
      yq3_in = {{RAMP_W{1'b0}}, v_2_ff} * {{CH_W{1'b0}}, RAMP_DEN - sf2_ff};
      yt3_in = {{RAMP_W{1'b0}}, v_2_ff} * {{CH_W{1'b0}}, RAMP_DEN - sg2_ff};
      pd3_in = {{(PD_W-PP_W){1'b0}}, pp2_ff} * {{(PD_W-16){1'b0}}, P_RECIP};
   end

   // Division by 979200 is a shift by 8 followed by division by 3825.
   always_comb begin
      qprod = {{(QP_W-RAMP_W){1'b0}}, yq3_ff[YQ_W-1:8]} * {{(QP_W-21){1'b0}}, Q_RECIP};
      tprod = {{(QP_W-RAMP_W){1'b0}}, yt3_ff[YQ_W-1:8]} * {{(QP_W-21){1'b0}}, Q_RECIP};
      q4_in = qprod[Q_SHIFT +: CH_W];
      t4_in = tprod[Q_SHIFT +: CH_W];
      p4_in = pd3_ff[P_SHIFT +: CH_W];
   end

   always_comb begin
      case (sec4_ff)
         SEC_RED_UP: begin
            red_in = v_4_ff; green_in = t4_ff;  blue_in = p4_ff;
         end
         SEC_GREEN_RISE: begin
            red_in = q4_ff;  green_in = v_4_ff; blue_in = p4_ff;
         end
         SEC_GREEN_UP: begin
            red_in = p4_ff;  green_in = v_4_ff; blue_in = t4_ff;
         end
         SEC_BLUE_RISE: begin
            red_in = p4_ff;  green_in = q4_ff;  blue_in = v_4_ff;
         end
         SEC_BLUE_UP: begin
            red_in = t4_ff;  green_in = p4_ff;  blue_in = v_4_ff;
         end
         default: begin
            red_in = v_4_ff; green_in = p4_ff;  blue_in = q4_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v1_ff        <= v1_in;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= v3_ff;
         rsp_valid_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      sec1_ff  <= sec1_in;
      f1_ff    <= f1_in;
      s1_ff    <= req_saturation;
      v_1_ff   <= req_brightness;

      sec2_ff  <= sec1_ff;
      v_2_ff   <= v_1_ff;
      sf2_ff   <= sf2_in;
      sg2_ff   <= sg2_in;
      pp2_ff   <= pp2_in;

      sec3_ff  <= sec2_ff;
      v_3_ff   <= v_2_ff;
      yq3_ff   <= yq3_in;
      yt3_ff   <= yt3_in;
      pd3_ff   <= pd3_in;

      sec4_ff  <= sec3_ff;
      v_4_ff   <= v_3_ff;
      q4_ff    <= q4_in;
      t4_ff    <= t4_in;
      p4_ff    <= p4_in;

      red_ff   <= red_in;
      green_ff <= green_in;
      blue_ff  <= blue_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_red   = red_ff;
   assign rsp_green = green_ff;
   assign rsp_blue  = blue_ff;

   // A result only ever follows an accepted transaction that has run through every stage.
   a_rsp_from_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, 5))
      else $error("result strobe without a matching transaction");

   // No component ever exceeds the brightness of its transaction.
   a_rsp_bounded: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_red <= $past(req_brightness, 5)) &&
                    (rsp_green <= $past(req_brightness, 5)) &&
                    (rsp_blue <= $past(req_brightness, 5)))
      else $error("component above brightness");

   // One component always carries the brightness itself.
   a_rsp_has_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_red == $past(req_brightness, 5)) ||
                    (rsp_green == $past(req_brightness, 5)) ||
                    (rsp_blue == $past(req_brightness, 5)))
      else $error("no component equals brightness");

   // Zero saturation gives a gray result.
   a_rsp_gray: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ($past(req_saturation, 5) == '0) |->
         (rsp_red == rsp_green) && (rsp_green == rsp_blue))
      else $error("unsaturated color is not gray");

endmodule

@@ verif/hsv_to_rgb_converter_top_tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// HSV to RGB converter testbench
// Sends directed and random colors through the converter and checks every
// strobed RGB result against an independent fixed-point prediction.
// ---------------------------------------------------------------------------
module hsv_to_rgb_converter_top_tb;
   import hsv2rgb_pkg::*;

   typedef struct packed {
      logic [CH_W-1:0] red;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] blue;
   } rgb_type;

   typedef struct {
      logic [HUE_W-1:0] hue;
      logic [CH_W-1:0]  saturation;
      logic [CH_W-1:0]  brightness;
      rgb_type          color;
   } pending_color_type;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   logic [HUE_W-1:0] req_hue;
   logic [CH_W-1:0]  req_saturation;
   logic [CH_W-1:0]  req_brightness;
   logic             rsp_valid;
   logic [CH_W-1:0]  rsp_red;
   logic [CH_W-1:0]  rsp_green;
   logic [CH_W-1:0]  rsp_blue;

   pending_color_type pending_colors[$];
   int                mismatch_count;
   int                sent_count;
   int                checked_count;
   int                gray_count;
   int                wrapped_count;
   int                sector_hits[6];
   bit                sender_gaps;

   hsv_to_rgb_converter_top dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_hue        (req_hue),
      .req_saturation (req_saturation),
      .req_brightness (req_brightness),
      .rsp_valid      (rsp_valid),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue)
   );

   always #5 clock = ~clock;

   // Fixed-point HSV to RGB: floor divisions throughout, ramps scaled by 255 * 3840.
   function automatic rgb_type hsv_color(logic [HUE_W-1:0] hue, logic [CH_W-1:0] sat,
                                         logic [CH_W-1:0] bright);
      rgb_type           c;
      longint unsigned   h;
      longint unsigned   s;
      longint unsigned   v;
      longint unsigned   den;
      longint unsigned   f;
      logic [CH_W-1:0]   p;
      logic [CH_W-1:0]   q;
      logic [CH_W-1:0]   t;
      logic [SEC_W-1:0]  sector;
      s   = sat;
      v   = bright;
      den = RAMP_DEN;
      if (sat == 0) begin
         c.red   = bright;
         c.green = bright;
         c.blue  = bright;
         return c;
      end
      h      = (hue >= FULL_TURN) ? 0 : hue;
      sector = SEC_W'(h / SECTOR_SPAN);
      f      = h % SECTOR_SPAN;
      p      = CH_W'((v * (UNIT - s)) / UNIT);
      q      = CH_W'((v * (den - s * f)) / den);
      t      = CH_W'((v * (den - s * (SECTOR_SPAN - f))) / den);
      case (sector)
         SEC_RED_UP: begin
            c.red = bright; c.green = t; c.blue = p;
         end
         SEC_GREEN_RISE: begin
            c.red = q; c.green = bright; c.blue = p;
         end
         SEC_GREEN_UP: begin
            c.red = p; c.green = bright; c.blue = t;
         end
         SEC_BLUE_RISE: begin
            c.red = p; c.green = q; c.blue = bright;
         end
         SEC_BLUE_UP: begin
            c.red = t; c.green = p; c.blue = bright;
         end
         default: begin
            c.red = bright; c.green = p; c.blue = q;
         end
      endcase
      return c;
   endfunction

   function automatic void note_mismatch(string what, pending_color_type want, int got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t: %s mismatch for hue=%0d sat=%0d val=%0d: %s %0d/%0d/%0d, got %0d",
                  $time, what, want.hue, want.saturation, want.brightness, "expected",
                  want.color.red, want.color.green, want.color.blue, got);
   endfunction

   // Each strobed result is compared against the oldest outstanding color.
   always @(posedge clock) begin
      pending_color_type want;
      if (!reset && rsp_valid) begin
         if (pending_colors.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("%0t: unexpected result %0d/%0d/%0d with nothing outstanding",
                        $time, rsp_red, rsp_green, rsp_blue);
         end else begin
            want = pending_colors.pop_front();
            checked_count++;
            if (rsp_red !== want.color.red)
               note_mismatch("red", want, rsp_red);
            if (rsp_green !== want.color.green)
               note_mismatch("green", want, rsp_green);
            if (rsp_blue !== want.color.blue)
               note_mismatch("blue", want, rsp_blue);
         end
      end
   end

   task automatic send_color(logic [HUE_W-1:0] hue, logic [CH_W-1:0] sat,
                             logic [CH_W-1:0] bright);
      pending_color_type entry;
      if (sender_gaps) begin
         while ($urandom_range(99) < 24) begin
            start <= 1'b0;
            @(posedge clock);
         end
      end
      start          <= 1'b1;
      req_hue        <= hue;
      req_saturation <= sat;
      req_brightness <= bright;
      do
         @(posedge clock);
      while (busy);
      entry.hue        = hue;
      entry.saturation = sat;
      entry.brightness = bright;
      entry.color      = hsv_color(hue, sat, bright);
      pending_colors.push_back(entry);
      sent_count++;
      if (sat == 0)
         gray_count++;
      else if (hue >= FULL_TURN)
         wrapped_count++;
      else
         sector_hits[hue / SECTOR_SPAN]++;
   endtask

   // Holds the sender off until every outstanding transaction has come back.
   task automatic drain_pending();
      start <= 1'b0;
      while (pending_colors.size() != 0)
         @(posedge clock);
   endtask

   task automatic test_zero_saturation();
      send_color(15'd12345, 8'd0, 8'd200);
      send_color(15'd32767, 8'd0, 8'd255);
      send_color(15'd0, 8'd0, 8'd0);
   endtask

   task automatic test_hue_wrap();
      send_color(15'd23039, 8'd255, 8'd255);
      send_color(15'd23040, 8'd255, 8'd255);
      send_color(15'd23041, 8'd255, 8'd128);
      send_color(15'd32767, 8'd200, 8'd180);
   endtask

   task automatic test_sector_routing();
      for (int sec = 0; sec < 6; sec++) begin
         send_color(HUE_W'(sec * SECTOR_SPAN), 8'd255, 8'd255);
         send_color(HUE_W'(sec * SECTOR_SPAN + SECTOR_SPAN - 1), 8'd170, 8'd201);
      end
   endtask

   task automatic test_channel_extremes();
      send_color(15'd0, 8'd255, 8'd0);
      send_color(15'd3839, 8'd1, 8'd1);
      send_color(15'd10000, 8'd255, 8'd1);
   endtask

   task automatic test_random_colors(int count);
      logic [HUE_W-1:0] hue;
      logic [CH_W-1:0]  sat;
      logic [CH_W-1:0]  bright;
      for (int i = 0; i < count; i++) begin
         // Most hues sit in the working range; some land past a full turn.
         if ($urandom_range(99) < 15)
            hue = HUE_W'($urandom_range(32767, FULL_TURN));
         else
            hue = HUE_W'($urandom_range(FULL_TURN - 1, 0));
         sat    = ($urandom_range(99) < 5) ? 8'd0 : CH_W'($urandom_range(255, 0));
         bright = CH_W'($urandom_range(255, 0));
         send_color(hue, sat, bright);
      end
   endtask

   initial begin
      int guard;
      clock          = 1'b0;
      reset          <= 1'b1;
      start          <= 1'b0;
      req_hue        <= '0;
      req_saturation <= '0;
      req_brightness <= '0;
      mismatch_count = 0;
      sent_count     = 0;
      checked_count  = 0;
      gray_count     = 0;
      wrapped_count  = 0;
      sender_gaps    = 1'b1;
      foreach (sector_hits[i])
         sector_hits[i] = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_zero_saturation();
      test_hue_wrap();
      test_sector_routing();
      test_channel_extremes();
      test_random_colors(400);
      drain_pending();
      // Back-to-back stretch with start held high every cycle.
      sender_gaps = 1'b0;
      test_random_colors(400);
      sender_gaps = 1'b1;

      start <= 1'b0;
      guard = 0;
      while (pending_colors.size() != 0 && guard < 1000) begin
         @(posedge clock);
         guard++;
      end
      repeat (10) @(posedge clock);
      if (pending_colors.size() != 0) begin
         mismatch_count += pending_colors.size();
         $display("%0d transactions never produced a result", pending_colors.size());
      end

      $display("Sent %0d colors, checked %0d results, %0d mismatches.",
               sent_count, checked_count, mismatch_count);
      $display("Sector hits %0d/%0d/%0d/%0d/%0d/%0d, gray %0d, wrapped hues %0d.",
               sector_hits[0], sector_hits[1], sector_hits[2], sector_hits[3],
               sector_hits[4], sector_hits[5], gray_count, wrapped_count);
      if (mismatch_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Timed out waiting for the converter.");
      $display("== FAIL ==");
      $finish;
   end

endmodule

@@ hsv_to_rgb_converter_top.f @@
rtl/hsv2rgb_pkg.sv
rtl/hsv_to_rgb_converter_top.sv
verif/hsv_to_rgb_converter_top_tb.sv
